/* rtl/ttsp_pkg.sv */
package ttsp_pkg;

  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned NT_COLS     = 32;

  localparam logic [7:0]  END_MARKER = 8'hFF;
  localparam logic [15:0] NAME_BASE  = 16'h2000;
  localparam logic [15:0] ATTR_BASE  = 16'h23C0;
  localparam logic [15:0] ATTR_END   = 16'h2400;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic KIND_TILE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    PH_ADDR_HI = 2'd0,
    PH_ADDR_LO = 2'd1,
    PH_SPEC    = 2'd2,
    PH_DATA    = 2'd3
  } phase_e;

  typedef struct packed {
    logic capture;
    logic decode;
    logic attr_step;
    logic rd_issue;
    logic skip;
    logic emit;
    logic end_emit;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic   restart;
    logic   finished;
    phase_e phase;
    logic   end_marker;
    logic   in_attr;
    logic   in_name;
    logic   run_zero;
    logic   cell_last;
    logic   cursor_in;
    logic   count_last;
    logic   out_free;
  } dp_sts_t;

endpackage

/* rtl/ttsp_ram.sv */
module ttsp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ttsp_ctrl.sv */
module ttsp_ctrl
  import ttsp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_ATTR   = 6'b000100,
    ST_READ   = 6'b001000,
    ST_EMIT   = 6'b010000,
    ST_END    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = ST_IDLE;
        if (!sts_i.restart && !sts_i.finished) begin
          unique case (sts_i.phase)
            PH_ADDR_HI: begin
              if (sts_i.end_marker) begin
                state_d = ST_END;
              end
            end
            PH_ADDR_LO, PH_SPEC: begin
              state_d = ST_IDLE;
            end
            PH_DATA: begin
              if (sts_i.in_attr) begin
                state_d = ST_ATTR;
              end else if (sts_i.in_name && !sts_i.run_zero) begin
                state_d = ST_READ;
              end else begin
                cmd_o.finish = 1'b1;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ATTR: begin
        cmd_o.attr_step = 1'b1;
        if (sts_i.cell_last) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts_i.cursor_in) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          cmd_o.skip = 1'b1;
          if (sts_i.count_last) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.count_last) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_END: begin
        if (sts_i.out_free) begin
          cmd_o.end_emit = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/ttsp_datapath.sv */
module ttsp_datapath
  import ttsp_pkg::*;
#(
  parameter int unsigned WINDOW_ROWS = 8,
  parameter int unsigned WINDOW_COLS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             s_tdata_i,
  input  logic                   s_tuser_i,
  input  ctrl_cmd_t              cmd_i,
  output dp_sts_t                sts_o,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,
  output logic                   m_tuser_o,
  output logic                   m_tlast_o
);

  localparam int unsigned PAL_DEPTH = WINDOW_ROWS * NT_COLS;
  localparam int unsigned PAL_AW    = $clog2(PAL_DEPTH);

  logic [7:0] byte_q;
  logic       op_q;

  phase_e         phase_q, phase_d;
  logic [15:0]    target_q, target_d;
  logic [5:0]     run_len_q, run_len_d;
  logic           vertical_q, vertical_d;
  logic           repeat_q, repeat_d;
  logic [5:0]     bytes_done_q, bytes_done_d;
  logic [7:0]     cur_row_q, cur_row_d;
  logic [7:0]     cur_col_q, cur_col_d;
  logic           finished_q, finished_d;
  logic [3:0]     cell_q, cell_d;
  logic [5:0]     count_q, count_d;
  logic [PAL_DEPTH-1:0] pal_valid_q, pal_valid_d;
  logic           pal_vld_rd_q;

  logic       out_valid_q, out_valid_d;
  logic       out_kind_q, out_kind_d;
  logic [4:0] out_col_q, out_col_d;
  logic [2:0] out_row_q, out_row_d;
  logic [7:0] out_tile_q, out_tile_d;
  logic [1:0] out_pal_q, out_pal_d;
  logic       out_last_q, out_last_d;

  logic              in_attr, in_name, out_free;
  logic [5:0]        needed, new_needed, bd_next;
  logic [9:0]        rel;
  logic              cur_in, cur_edge;
  logic [2:0]        cur_r;
  logic [4:0]        cur_c;
  logic [PAL_AW-1:0] rd_addr;
  logic [6:0]        offset;
  logic [5:0]        a_nr;
  logic [4:0]        a_c;
  logic [2:0]        a_r;
  logic [1:0]        a_pal;
  logic              a_in;
  logic              ram_we;
  logic [PAL_AW-1:0] ram_waddr;
  logic [1:0]        ram_rdata;

  assign in_attr  = (target_q >= ATTR_BASE) && (target_q < ATTR_END);
  assign in_name  = (target_q >= NAME_BASE) && (target_q < ATTR_BASE);
  assign needed   = in_attr ? run_len_q : (repeat_q ? 6'd1 : run_len_q);
  assign bd_next  = bytes_done_q + 6'd1;
  assign rel      = 10'(target_q - NAME_BASE);
  assign out_free = !out_valid_q || m_tready_i;

  assign new_needed = in_attr ? byte_q[5:0] : (byte_q[6] ? 6'd1 : byte_q[5:0]);

  assign cur_in   = (cur_row_q != 8'd0) && (cur_row_q <= 8'(WINDOW_ROWS))
                    && (cur_col_q < 8'(WINDOW_COLS));
  assign cur_r    = 3'(cur_row_q - 8'd1);
  assign cur_c    = cur_col_q[4:0];
  assign rd_addr  = PAL_AW'({cur_r, cur_c});
  assign cur_edge = vertical_q ? (cur_row_q == 8'(WINDOW_ROWS))
                               : (cur_col_q == 8'(WINDOW_COLS - 1));

  assign offset = 7'(target_q[5:0]) + 7'(bytes_done_q);
  assign a_nr   = {offset[6:3], 2'b00} + 6'({cell_q[3], cell_q[1]});
  assign a_c    = {offset[2:0], 2'b00} + 5'({cell_q[2], cell_q[0]});
  assign a_r    = 3'(a_nr - 6'd1);
  assign a_pal  = 2'(byte_q >> {cell_q[3:2], 1'b0});
  assign a_in   = (a_nr != 6'd0) && (a_nr <= 6'(WINDOW_ROWS))
                  && ({1'b0, a_c} < 6'(WINDOW_COLS));

  assign ram_we    = cmd_i.attr_step && a_in;
  assign ram_waddr = PAL_AW'({a_r, a_c});

  ttsp_ram #(
    .WIDTH(2),
    .DEPTH(PAL_DEPTH)
  ) u_pal_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(a_pal),
    .re_i   (cmd_i.rd_issue),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    phase_d      = phase_q;
    target_d     = target_q;
    run_len_d    = run_len_q;
    vertical_d   = vertical_q;
    repeat_d     = repeat_q;
    bytes_done_d = bytes_done_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    finished_d   = finished_q;
    cell_d       = cell_q;
    count_d      = count_q;
    pal_valid_d  = pal_valid_q;
    out_valid_d  = out_valid_q;
    out_kind_d   = out_kind_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    out_tile_d   = out_tile_q;
    out_pal_d    = out_pal_q;
    out_last_d   = out_last_q;

    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.decode) begin
      if (op_q == OP_RESTART) begin
        phase_d      = PH_ADDR_HI;
        target_d     = '0;
        run_len_d    = '0;
        vertical_d   = 1'b0;
        repeat_d     = 1'b0;
        bytes_done_d = '0;
        cur_row_d    = '0;
        cur_col_d    = '0;
        finished_d   = 1'b0;
        pal_valid_d  = '0;
      end else if (!finished_q) begin
        unique case (phase_q)
          PH_ADDR_HI: begin
            if (byte_q != END_MARKER) begin
              target_d = {byte_q, 8'h00};
              phase_d  = PH_ADDR_LO;
            end
          end
          PH_ADDR_LO: begin
            target_d = {target_q[15:8], byte_q};
            phase_d  = PH_SPEC;
          end
          PH_SPEC: begin
            run_len_d    = byte_q[5:0];
            vertical_d   = byte_q[7];
            repeat_d     = byte_q[6];
            bytes_done_d = '0;
            if (in_name) begin
              cur_row_d = 8'(rel[9:5]);
              cur_col_d = 8'(rel[4:0]);
            end
            phase_d = (new_needed == 6'd0) ? PH_ADDR_HI : PH_DATA;
          end
          PH_DATA: begin
            cell_d  = '0;
            count_d = repeat_q ? run_len_q : 6'd1;
          end
          default: phase_d = PH_ADDR_HI;
        endcase
      end
    end

    if (cmd_i.attr_step) begin
      cell_d = cell_q + 4'd1;
      if (a_in) begin
        pal_valid_d[ram_waddr] = 1'b1;
      end
    end

    if (cmd_i.skip || cmd_i.emit) begin
      count_d = count_q - 6'd1;
      if (vertical_q) begin
        cur_row_d = cur_row_q + 8'd1;
      end else begin
        cur_col_d = cur_col_q + 8'd1;
      end
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_TILE;
      out_col_d   = cur_c;
      out_row_d   = cur_r;
      out_tile_d  = byte_q;
      out_pal_d   = pal_vld_rd_q ? ram_rdata : 2'd0;
      out_last_d  = (count_q == 6'd1) || cur_edge;
    end

    if (cmd_i.end_emit) begin
      finished_d  = 1'b1;
      out_valid_d = 1'b1;
      out_kind_d  = KIND_END;
      out_col_d   = '0;
      out_row_d   = '0;
      out_tile_d  = '0;
      out_pal_d   = '0;
      out_last_d  = 1'b1;
    end

    if (cmd_i.finish) begin
      bytes_done_d = bd_next;
      if ((bd_next >= needed) || (bd_next == 6'd0)) begin
        phase_d = PH_ADDR_HI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_ADDR_HI;
      target_q     <= '0;
      run_len_q    <= '0;
      vertical_q   <= 1'b0;
      repeat_q     <= 1'b0;
      bytes_done_q <= '0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      finished_q   <= 1'b0;
      cell_q       <= '0;
      count_q      <= '0;
      pal_valid_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      target_q     <= target_d;
      run_len_q    <= run_len_d;
      vertical_q   <= vertical_d;
      repeat_q     <= repeat_d;
      bytes_done_q <= bytes_done_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      finished_q   <= finished_d;
      cell_q       <= cell_d;
      count_q      <= count_d;
      pal_valid_q  <= pal_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= s_tdata_i;
      op_q   <= s_tuser_i;
    end
    if (cmd_i.rd_issue) begin
      pal_vld_rd_q <= pal_valid_q[rd_addr];
    end
    out_kind_q <= out_kind_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_tile_q <= out_tile_d;
    out_pal_q  <= out_pal_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    sts_o            = '0;
    sts_o.restart    = (op_q == OP_RESTART);
    sts_o.finished   = finished_q;
    sts_o.phase      = phase_q;
    sts_o.end_marker = (byte_q == END_MARKER);
    sts_o.in_attr    = in_attr;
    sts_o.in_name    = in_name;
    sts_o.run_zero   = repeat_q && (run_len_q == 6'd0);
    sts_o.cell_last  = (cell_q == 4'hF);
    sts_o.cursor_in  = cur_in;
    sts_o.count_last = (count_q == 6'd1);
    sts_o.out_free   = out_free;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OUT_TDATA_W'({out_pal_q, out_tile_q, out_row_q, out_col_q});
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

endmodule

/* rtl/tile_transfer_stream_parser.sv */
// Tile transfer stream parser.
// Slave side: one word per stream byte; tuser = 1 restarts the parser and clears
// the palette map, tuser = 0 carries a stream byte in tdata[7:0].
// Master side: tile writes (tuser = 0) and one end word (tuser = 1) after an end
// marker; tlast flags the final word caused by one input word.
// The block takes one input word at a time. Header, spec, restart and ignored
// data words need only the decode state. An attribute word then steps through
// its sixteen palette cells and writes those inside the window through the
// single RAM write port, one per cycle. A tile word then handles each write in
// turn: an emitted write reads the palette RAM, then loads the output register
// when that is free; a dropped write is skipped. The end word loads it likewise.
// The output register holds a finished word while the next input is taken;
// a stalled receiver blocks the parser only when a new word must be loaded.
// Reset clears the parser state, the palette map valid bits and the output valid
// flag; the palette RAM contents need no clearing afterwards.
module tile_transfer_stream_parser
  import ttsp_pkg::*;
#(
  parameter int unsigned WINDOW_ROWS = 8,
  parameter int unsigned WINDOW_COLS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] stream_byte
  input  logic                   s_axis_tuser,  // [0] operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [4:0] column, [7:5] row, [15:8] tile, [17:16] palette, [23:18] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,  // [0] kind
  output logic                   m_axis_tlast
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  ttsp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ttsp_datapath #(
    .WINDOW_ROWS(WINDOW_ROWS),
    .WINDOW_COLS(WINDOW_COLS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .m_tready_i(m_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser),
    .m_tlast_o (m_axis_tlast)
  );

endmodule

/* rtl/ttsp_checker.sv */
module ttsp_checker
  import ttsp_pkg::*;
#(
  parameter int unsigned WINDOW_ROWS = 8,
  parameter int unsigned WINDOW_COLS = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  a_end_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_END) |->
      m_axis_tlast && (m_axis_tdata == '0))
    else $error("end word carries data or lacks tlast");

  a_tile_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_TILE) |->
      (32'(m_axis_tdata[4:0]) < WINDOW_COLS) && (32'(m_axis_tdata[7:5]) < WINDOW_ROWS)
      && (m_axis_tdata[OUT_TDATA_W-1:18] == '0))
    else $error("tile write outside the window");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous word is still decoding");

endmodule

bind tile_transfer_stream_parser ttsp_checker #(
  .WINDOW_ROWS(WINDOW_ROWS),
  .WINDOW_COLS(WINDOW_COLS)
) u_ttsp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

/* tb/tile_write_checker.sv */
`timescale 1ns / 1ps
module tile_write_checker
  import ttsp_pkg::*;
#(
  parameter int unsigned WINDOW_ROWS = 8,
  parameter int unsigned WINDOW_COLS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tuser,
  input  logic                   m_axis_tlast,
  output int                     mismatches_o,
  output int                     words_due_o
);

  typedef struct packed {
    logic       kind;
    logic [5:0] pad;
    logic [1:0] palette;
    logic [7:0] tile;
    logic [2:0] row;
    logic [4:0] column;
    logic       last;
  } tile_word_t;

  phase_e      phase;
  logic [15:0] addr;
  logic [5:0]  run_len;
  logic        vert;
  logic        rpt;
  logic [5:0]  done_cnt;
  logic [7:0]  cur_row;
  logic [7:0]  cur_col;
  logic        finished;
  logic [1:0]  pal_map [256];

  tile_word_t  tile_words_due [$];
  tile_word_t  held_word;
  logic        holding;
  int          mismatches;

  function automatic logic addr_in_attr();
    return addr >= ATTR_BASE && addr < ATTR_END;
  endfunction

  function automatic logic addr_in_name();
    return addr >= NAME_BASE && addr < ATTR_BASE;
  endfunction

  function automatic int data_words_needed();
    if (addr_in_attr()) return int'(run_len);
    return rpt ? 1 : int'(run_len);
  endfunction

  task automatic clear_state();
    phase    = PH_ADDR_HI;
    addr     = '0;
    run_len  = '0;
    vert     = 1'b0;
    rpt      = 1'b0;
    done_cnt = '0;
    cur_row  = '0;
    cur_col  = '0;
    finished = 1'b0;
    foreach (pal_map[i]) pal_map[i] = 2'd0;
  endtask

  // hold each new word back so the final one of an input word gets tlast
  task automatic emit_word(input tile_word_t w);
    if (holding) tile_words_due.push_back(held_word);
    held_word = w;
    holding   = 1'b1;
  endtask

  task automatic paint_attr(input int offset, input logic [7:0] attr);
    int row_start, col_start, qc, qr, nr, c, q, dy, dx;
    row_start = (offset >> 3) << 2;
    col_start = (offset & 7) << 2;
    for (q = 0; q < 4; q++) begin
      qc = col_start + ((q & 1) << 1);
      qr = row_start + ((q >> 1) << 1);
      for (dy = 0; dy < 2; dy++) begin
        nr = qr + dy;
        if (nr == 0 || nr > int'(WINDOW_ROWS)) continue;
        for (dx = 0; dx < 2; dx++) begin
          c = qc + dx;
          if (c < int'(WINDOW_COLS)) pal_map[((nr - 1) * 32 + c) & 255] = attr[2*q +: 2];
        end
      end
    end
  endtask

  task automatic place_tile(input logic [7:0] tile);
    tile_word_t w;
    int         r;
    if (cur_row > 0 && cur_row <= WINDOW_ROWS && cur_col < WINDOW_COLS) begin
      r         = int'(cur_row) - 1;
      w         = '0;
      w.kind    = KIND_TILE;
      w.column  = cur_col[4:0];
      w.row     = 3'(r);
      w.tile    = tile;
      w.palette = pal_map[(r * 32 + int'(cur_col)) & 255];
      emit_word(w);
    end
    if (vert) cur_row = cur_row + 8'd1;
    else cur_col = cur_col + 8'd1;
  endtask

  task automatic parse_stream_word(input logic op, input logic [7:0] b);
    logic [15:0] rel;
    tile_word_t  w;
    if (op == OP_RESTART) begin
      clear_state();
    end else if (!finished) begin
      unique case (phase)
        PH_ADDR_HI: begin
          if (b == END_MARKER) begin
            finished = 1'b1;
            w        = '0;
            w.kind   = KIND_END;
            emit_word(w);
          end else begin
            addr  = {b, 8'h00};
            phase = PH_ADDR_LO;
          end
        end
        PH_ADDR_LO: begin
          addr[7:0] = b;
          phase     = PH_SPEC;
        end
        PH_SPEC: begin
          run_len  = b[5:0];
          vert     = b[7];
          rpt      = b[6];
          done_cnt = '0;
          if (addr_in_name()) begin
            rel     = addr - NAME_BASE;
            cur_row = rel[12:5];
            cur_col = {3'b000, rel[4:0]};
          end
          phase = (data_words_needed() == 0) ? PH_ADDR_HI : PH_DATA;
        end
        default: begin
          if (addr_in_attr()) begin
            paint_attr(int'(addr - ATTR_BASE) + int'(done_cnt), b);
          end else if (addr_in_name()) begin
            if (rpt) repeat (run_len) place_tile(b);
            else place_tile(b);
          end
          done_cnt = done_cnt + 6'd1;
          if (int'(done_cnt) >= data_words_needed() || done_cnt == 6'd0) phase = PH_ADDR_HI;
        end
      endcase
    end
    if (holding) begin
      held_word.last = 1'b1;
      tile_words_due.push_back(held_word);
      holding = 1'b0;
    end
  endtask

  task automatic check_tile_word();
    tile_word_t got;
    tile_word_t want;
    got.kind    = m_axis_tuser;
    got.pad     = m_axis_tdata[23:18];
    got.palette = m_axis_tdata[17:16];
    got.tile    = m_axis_tdata[15:8];
    got.row     = m_axis_tdata[7:5];
    got.column  = m_axis_tdata[4:0];
    got.last    = m_axis_tlast;
    if (tile_words_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: kind=%0d col=%0d row=%0d tile=%02h pal=%0d last=%0d",
                 got.kind, got.column, got.row, got.tile, got.palette, got.last);
    end else begin
      want = tile_words_due.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected kind=%0d col=%0d row=%0d tile=%02h pal=%0d last=%0d pad=%0h",
                   want.kind, want.column, want.row, want.tile, want.palette, want.last,
                   want.pad);
          $display("          got      kind=%0d col=%0d row=%0d tile=%02h pal=%0d last=%0d pad=%0h",
                   got.kind, got.column, got.row, got.tile, got.palette, got.last, got.pad);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      tile_words_due.delete();
      holding    = 1'b0;
      mismatches = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_stream_word(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_tile_word();
    end
    mismatches_o <= mismatches;
    words_due_o  <= tile_words_due.size();
  end

endmodule

/* tb/tb_tile_transfer_stream_parser.sv */
`timescale 1ns / 1ps
module tb_tile_transfer_stream_parser;
  import ttsp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int WORD_TARGET = 420;
  localparam int HOLD_CYCLES = 600;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  int   mismatches;
  int   words_due;
  int   words_sent  = 0;
  int   cycle_count = 0;
  logic steady      = 1'b0;
  logic hold_done   = 1'b0;

  tile_transfer_stream_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  tile_write_checker u_tile_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches_o  (mismatches),
    .words_due_o   (words_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_word(input logic op, input logic [7:0] b);
    while (!steady && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    steady = words_sent >= 200 && words_sent < 300;
    @(negedge clk_i);
  endtask

  task automatic send_header(input logic [15:0] a, input logic [7:0] spec);
    send_word(OP_BYTE, a[15:8]);
    send_word(OP_BYTE, a[7:0]);
    send_word(OP_BYTE, spec);
  endtask

  task automatic send_random_group();
    int          sel;
    int          len;
    int          n;
    logic [15:0] a;
    logic [7:0]  spec;
    sel = $urandom_range(99);
    if (sel < 45) begin
      a = NAME_BASE + 16'($urandom_range(32, 9 * 32 + 31));
    end else if (sel < 55) begin
      a = NAME_BASE + 16'($urandom_range(0, 16'h3BF));
    end else if (sel < 80) begin
      a = ATTR_BASE + 16'($urandom_range(0, 63));
    end else begin
      a = 16'($urandom);
      if (a[15:8] == END_MARKER) a[15:8] = 8'hFE;
    end
    len  = ($urandom_range(99) < 85) ? $urandom_range(0, 6) : $urandom_range(0, 63);
    spec = {1'($urandom), 1'($urandom), 6'(len)};
    send_header(a, spec);
    if (a >= ATTR_BASE && a < ATTR_END) n = len;
    else n = spec[6] ? 1 : len;
    repeat (n) send_word(OP_BYTE, 8'($urandom));
  endtask

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int held;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && words_sent >= 60) begin
        m_axis_tready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk_i);
        hold_done = 1'b1;
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 26);
    end
  end

  initial begin
    int pick;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = OP_BYTE;
    s_axis_tdata  = 8'h00;
    rst_ni        = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_header(16'h23C0, 8'h02);
    send_word(OP_BYTE, 8'hE4);
    send_word(OP_BYTE, 8'h1B);
    send_header(16'h2022, 8'h01);
    send_word(OP_BYTE, END_MARKER);
    send_header(16'h201F, 8'hCA);
    send_word(OP_BYTE, 8'h5A);
    send_header(16'h2118, 8'h4A);
    send_word(OP_BYTE, 8'hC3);
    send_header(16'h2040, 8'h40);
    send_word(OP_BYTE, 8'h33);
    send_header(16'h3F00, 8'h01);
    send_word(OP_BYTE, 8'h77);
    send_word(OP_BYTE, END_MARKER);
    send_word(OP_BYTE, 8'h12);
    send_word(OP_RESTART, 8'hA5);

    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        send_random_group();
      end else if (pick < 89) begin
        send_word(OP_BYTE, 8'($urandom));
        send_word(OP_RESTART, 8'($urandom));
      end else if (pick < 93) begin
        send_word(OP_BYTE, 8'($urandom_range(0, 254)));
        send_word(OP_BYTE, 8'($urandom));
        send_word(OP_RESTART, 8'($urandom));
      end else if (pick < 96) begin
        send_word(OP_RESTART, 8'($urandom));
      end else begin
        send_word(OP_BYTE, END_MARKER);
        repeat ($urandom_range(0, 3)) send_word(OP_BYTE, 8'($urandom));
        send_word(OP_RESTART, 8'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (words_due != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && words_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
